FILE: rtl/plob_pkg.sv
// Shared types and constants for the price-level order book matcher.
// No dependencies; imported by plob_front, plob_book and the top level.
package plob_pkg;

  localparam int unsigned LEVELS_DEF     = 64;
  localparam int unsigned PRICE_BITS_DEF = 32;
  localparam int unsigned SIZE_W         = 32;
  localparam int unsigned PORT_PX_W      = 32;
  localparam int unsigned FIFO_DEPTH     = 2;

  typedef enum logic [1:0] {
    OP_NEW    = 2'd0,
    OP_REDUCE = 2'd1,
    OP_MODIFY = 2'd2,
    OP_NONE   = 2'd3
  } plob_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } plob_status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_RD,
    S_RED_CMP,
    S_POSTRED,
    S_SWP_RD,
    S_SWP_CMP,
    S_RES,
    S_FND_RD,
    S_FND_CMP,
    S_POS_RD,
    S_POS_CMP,
    S_SHUP_RD,
    S_SHUP_WR,
    S_INS,
    S_SHDN_RD,
    S_SHDN_WR,
    S_TOP,
    S_OUT
  } plob_state_e;

  // classified word passed from the front to the back
  typedef struct packed {
    plob_op_e               op;
    logic                   buy;
    logic [PORT_PX_W-1:0]   price;
    logic [SIZE_W-1:0]      size;
    logic [PORT_PX_W-1:0]   new_price;
    logic [SIZE_W-1:0]      new_size;
  } plob_cmd_t;

endpackage

FILE: rtl/plob_front.sv
// Front end: accepts input words, decodes the op and queues them for the book.
// Depends on plob_pkg.
module plob_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    op_i,
  input  logic                          side_i,
  input  logic [plob_pkg::PORT_PX_W-1:0] price_i,
  input  logic [plob_pkg::SIZE_W-1:0]   size_i,
  input  logic [plob_pkg::PORT_PX_W-1:0] new_price_i,
  input  logic [plob_pkg::SIZE_W-1:0]   new_size_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output plob_pkg::plob_cmd_t           cmd_o
);
  import plob_pkg::*;

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  plob_cmd_t        fifo_q [FIFO_DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  plob_cmd_t        cmd_in;
  logic             do_push, do_pop;

  always_comb begin
    cmd_in.buy       = side_i;
    cmd_in.price     = price_i;
    cmd_in.size      = size_i;
    cmd_in.new_price = new_price_i;
    cmd_in.new_size  = new_size_i;
    case (op_i)
      OP_NEW:    cmd_in.op = OP_NEW;
      OP_REDUCE: cmd_in.op = OP_REDUCE;
      OP_MODIFY: cmd_in.op = OP_MODIFY;
      default:   cmd_in.op = OP_NONE;
    endcase
  end

  assign full        = (cnt_q == CW'(FIFO_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/plob_book.sv
// Back end: level tables in memory, sequencer for sweep, find, insert and remove,
// and the one-entry result register. Depends on plob_pkg.
module plob_book #(
  parameter int unsigned LEVELS     = plob_pkg::LEVELS_DEF,
  parameter int unsigned PRICE_BITS = plob_pkg::PRICE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  plob_pkg::plob_cmd_t           cmd_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [plob_pkg::SIZE_W-1:0]   filled_size_o,
  output logic [plob_pkg::SIZE_W-1:0]   rested_size_o,
  output logic [1:0]                    status_o,
  output logic [plob_pkg::PORT_PX_W-1:0] best_bid_o,
  output logic [plob_pkg::PORT_PX_W-1:0] best_ask_o,
  output logic                          bid_empty_o,
  output logic                          ask_empty_o
);
  import plob_pkg::*;

  localparam int unsigned AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CW = $clog2(LEVELS + 1);
  localparam int unsigned XW = PRICE_BITS;

  // level tables, index 0 is the best level
  logic [XW-1:0]     bid_px [LEVELS];
  logic [SIZE_W-1:0] bid_sz [LEVELS];
  logic [XW-1:0]     ask_px [LEVELS];
  logic [SIZE_W-1:0] ask_sz [LEVELS];
  logic [XW-1:0]     rd_bid_px_q, rd_ask_px_q;
  logic [SIZE_W-1:0] rd_bid_sz_q, rd_ask_sz_q;

  logic [AW-1:0]     ra, wa;
  logic              we;
  logic [XW-1:0]     wpx;
  logic [SIZE_W-1:0] wsz;

  plob_state_e       state_q, state_d;
  plob_op_e          op_q, op_d;
  logic              buy_q, buy_d, side_q, side_d;
  logic [XW-1:0]     key_q, key_d, npx_q, npx_d;
  logic [SIZE_W-1:0] amt_q, amt_d, nqty_q, nqty_d, need_q, need_d, qty0_q, qty0_d;
  logic [CW-1:0]     idx_q, idx_d, jx_q, jx_d;
  logic              ret_swp_q, ret_swp_d;
  logic              st_red_q, st_red_d, full_q, full_d;
  logic [SIZE_W-1:0] rested_q, rested_d;
  logic [CW-1:0]     bid_cnt_q, bid_cnt_d, ask_cnt_q, ask_cnt_d;

  logic              res_valid_q, res_valid_d;
  logic [SIZE_W-1:0] res_filled_q, res_filled_d, res_rested_q, res_rested_d;
  plob_status_e      res_status_q, res_status_d;
  logic [PORT_PX_W-1:0] res_bb_q, res_bb_d, res_ba_q, res_ba_d;
  logic              res_be_q, res_be_d, res_ae_q, res_ae_d;

  logic [CW-1:0]     cnt_sel, idx_inc;
  logic [XW-1:0]     rd_px;
  logic [SIZE_W-1:0] rd_sz;
  logic [SIZE_W:0]   sat_sum;
  logic              crosses, better;

  assign cnt_sel = side_q ? bid_cnt_q : ask_cnt_q;
  assign rd_px   = side_q ? rd_bid_px_q : rd_ask_px_q;
  assign rd_sz   = side_q ? rd_bid_sz_q : rd_ask_sz_q;
  assign idx_inc = idx_q + 1'b1;
  assign sat_sum = {1'b0, rd_sz} + {1'b0, need_q};
  // opposite side level still crosses the incoming limit
  assign crosses = buy_q ? (rd_px <= key_q) : (rd_px >= key_q);
  // own side level is worse than the new price: insert before it
  assign better  = buy_q ? (rd_px < key_q) : (rd_px > key_q);

  assign empty         = !res_valid_q;
  assign filled_size_o = res_filled_q;
  assign rested_size_o = res_rested_q;
  assign status_o      = res_status_q;
  assign best_bid_o    = res_bb_q;
  assign best_ask_o    = res_ba_q;
  assign bid_empty_o   = res_be_q;
  assign ask_empty_o   = res_ae_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    buy_d        = buy_q;
    side_d       = side_q;
    key_d        = key_q;
    npx_d        = npx_q;
    amt_d        = amt_q;
    nqty_d       = nqty_q;
    need_d       = need_q;
    qty0_d       = qty0_q;
    idx_d        = idx_q;
    jx_d         = jx_q;
    ret_swp_d    = ret_swp_q;
    st_red_d     = st_red_q;
    full_d       = full_q;
    rested_d     = rested_q;
    bid_cnt_d    = bid_cnt_q;
    ask_cnt_d    = ask_cnt_q;
    res_valid_d  = res_valid_q && !pop;
    res_filled_d = res_filled_q;
    res_rested_d = res_rested_q;
    res_status_d = res_status_q;
    res_bb_d     = res_bb_q;
    res_ba_d     = res_ba_q;
    res_be_d     = res_be_q;
    res_ae_d     = res_ae_q;
    cmd_ready_o  = 1'b0;
    ra           = '0;
    we           = 1'b0;
    wa           = idx_q[AW-1:0];
    wpx          = rd_px;
    wsz          = rd_sz;

    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d     = cmd_i.op;
          buy_d    = cmd_i.buy;
          side_d   = cmd_i.buy;
          key_d    = XW'(cmd_i.price);
          npx_d    = XW'(cmd_i.new_price);
          amt_d    = cmd_i.size;
          nqty_d   = cmd_i.new_size;
          need_d   = cmd_i.size;
          qty0_d   = cmd_i.size;
          idx_d    = '0;
          st_red_d = 1'b0;
          full_d   = 1'b0;
          rested_d = '0;
          case (cmd_i.op)
            OP_NEW: begin
              side_d  = !cmd_i.buy;
              state_d = S_SWP_RD;
            end
            OP_REDUCE, OP_MODIFY: state_d = S_RED_RD;
            default: begin
              qty0_d  = '0;
              need_d  = '0;
              state_d = S_TOP;
            end
          endcase
        end
      end

      S_RED_RD: begin
        ra = idx_q[AW-1:0];
        if (idx_q >= cnt_sel) begin
          st_red_d = 1'b1;
          state_d  = S_POSTRED;
        end else begin
          state_d = S_RED_CMP;
        end
      end

      S_RED_CMP: begin
        if (rd_px == key_q) begin
          if (amt_q >= rd_sz) begin
            ret_swp_d = 1'b0;
            state_d   = S_SHDN_RD;
          end else begin
            we      = 1'b1;
            wsz     = rd_sz - amt_q;
            state_d = S_POSTRED;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = S_RED_RD;
        end
      end

      S_POSTRED: begin
        if (op_q == OP_MODIFY) begin
          key_d   = npx_q;
          need_d  = nqty_q;
          qty0_d  = nqty_q;
          side_d  = !buy_q;
          state_d = S_SWP_RD;
        end else begin
          qty0_d  = '0;
          need_d  = '0;
          state_d = S_TOP;
        end
      end

      S_SWP_RD: begin
        ra = '0;
        if (need_q == '0 || cnt_sel == '0) begin
          state_d = S_RES;
        end else begin
          state_d = S_SWP_CMP;
        end
      end

      S_SWP_CMP: begin
        wa = '0;
        if (!crosses) begin
          state_d = S_RES;
        end else if (rd_sz <= need_q) begin
          need_d    = need_q - rd_sz;
          idx_d     = '0;
          ret_swp_d = 1'b1;
          state_d   = S_SHDN_RD;
        end else begin
          we      = 1'b1;
          wsz     = rd_sz - need_q;
          need_d  = '0;
          state_d = S_RES;
        end
      end

      S_RES: begin
        side_d = buy_q;
        idx_d  = '0;
        if (need_q == '0) begin
          state_d = S_TOP;
        end else begin
          state_d = S_FND_RD;
        end
      end

      S_FND_RD: begin
        ra = idx_q[AW-1:0];
        if (idx_q >= cnt_sel) begin
          idx_d = '0;
          if (cnt_sel >= CW'(LEVELS)) begin
            full_d  = 1'b1;
            state_d = S_TOP;
          end else begin
            state_d = S_POS_RD;
          end
        end else begin
          state_d = S_FND_CMP;
        end
      end

      S_FND_CMP: begin
        if (rd_px == key_q) begin
          we       = 1'b1;
          wsz      = sat_sum[SIZE_W] ? '1 : sat_sum[SIZE_W-1:0];
          rested_d = need_q;
          state_d  = S_TOP;
        end else begin
          idx_d   = idx_inc;
          state_d = S_FND_RD;
        end
      end

      S_POS_RD: begin
        ra   = idx_q[AW-1:0];
        jx_d = cnt_sel;
        if (idx_q >= cnt_sel) begin
          state_d = S_SHUP_RD;
        end else begin
          state_d = S_POS_CMP;
        end
      end

      S_POS_CMP: begin
        if (better) begin
          state_d = S_SHUP_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = S_POS_RD;
        end
      end

      // open a hole at idx by moving entries up, top first
      S_SHUP_RD: begin
        ra = AW'(jx_q - 1'b1);
        if (jx_q == idx_q) begin
          state_d = S_INS;
        end else begin
          state_d = S_SHUP_WR;
        end
      end

      S_SHUP_WR: begin
        we      = 1'b1;
        wa      = jx_q[AW-1:0];
        jx_d    = jx_q - 1'b1;
        state_d = S_SHUP_RD;
      end

      S_INS: begin
        we       = 1'b1;
        wpx      = key_q;
        wsz      = need_q;
        rested_d = need_q;
        if (side_q) begin
          bid_cnt_d = bid_cnt_q + 1'b1;
        end else begin
          ask_cnt_d = ask_cnt_q + 1'b1;
        end
        state_d = S_TOP;
      end

      // close the gap at idx by moving entries down
      S_SHDN_RD: begin
        ra = idx_inc[AW-1:0];
        if (idx_inc >= cnt_sel) begin
          if (side_q) begin
            bid_cnt_d = bid_cnt_q - 1'b1;
          end else begin
            ask_cnt_d = ask_cnt_q - 1'b1;
          end
          state_d = ret_swp_q ? S_SWP_RD : S_POSTRED;
        end else begin
          state_d = S_SHDN_WR;
        end
      end

      S_SHDN_WR: begin
        we      = 1'b1;
        idx_d   = idx_inc;
        state_d = S_SHDN_RD;
      end

      S_TOP: begin
        ra      = '0;
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!res_valid_q || pop) begin
          res_valid_d  = 1'b1;
          res_filled_d = qty0_q - need_q;
          res_rested_d = rested_q;
          res_status_d = full_q ? ST_FULL : (st_red_q ? ST_NOT_FOUND : ST_OK);
          res_bb_d     = (bid_cnt_q != '0) ? PORT_PX_W'(rd_bid_px_q) : '0;
          res_ba_d     = (ask_cnt_q != '0) ? PORT_PX_W'(rd_ask_px_q) : '0;
          res_be_d     = (bid_cnt_q == '0);
          res_ae_d     = (ask_cnt_q == '0);
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_bid_px_q <= bid_px[ra];
    rd_bid_sz_q <= bid_sz[ra];
    rd_ask_px_q <= ask_px[ra];
    rd_ask_sz_q <= ask_sz[ra];
    if (we && side_q) begin
      bid_px[wa] <= wpx;
      bid_sz[wa] <= wsz;
    end
    if (we && !side_q) begin
      ask_px[wa] <= wpx;
      ask_sz[wa] <= wsz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bid_cnt_q   <= '0;
      ask_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bid_cnt_q   <= bid_cnt_d;
      ask_cnt_q   <= ask_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    buy_q        <= buy_d;
    side_q       <= side_d;
    key_q        <= key_d;
    npx_q        <= npx_d;
    amt_q        <= amt_d;
    nqty_q       <= nqty_d;
    need_q       <= need_d;
    qty0_q       <= qty0_d;
    idx_q        <= idx_d;
    jx_q         <= jx_d;
    ret_swp_q    <= ret_swp_d;
    st_red_q     <= st_red_d;
    full_q       <= full_d;
    rested_q     <= rested_d;
    res_filled_q <= res_filled_d;
    res_rested_q <= res_rested_d;
    res_status_q <= res_status_d;
    res_bb_q     <= res_bb_d;
    res_ba_q     <= res_ba_d;
    res_be_q     <= res_be_d;
    res_ae_q     <= res_ae_d;
  end

endmodule

FILE: rtl/price_level_order_book_matcher.sv
// Price-level order book matcher, top level.
// Input side is a queue write port: a word is taken when push is high and full is low.
// Result side is a queue read port: while empty is low the oldest result sits on the
// result ports and is taken when pop is high.
// Each word gives exactly one result word.
// A two-entry command queue decouples the input from the book sequencer, and a
// one-entry result register lets the next word be worked on while a result waits.
// Latency is data dependent; the sequencer works on one word at a time. Price search
// reads and compares each level scanned, inserting or removing a level reads and writes
// each level moved, and each swept level is removed by the same shift. An op 3 word goes
// straight to the top-of-book read and the output step, a reduce on an empty side ends
// its search at once, and a new order resting on an empty book passes the sweep, find,
// position and insert steps. The worst case is a modify sweeping a full opposite side.
// Reset empties both sides of the book and both queues. A stalled result holds
// the sequencer at its last step; the command queue then fills and full rises.
// Depends on plob_pkg, plob_front and plob_book.
module price_level_order_book_matcher #(
  parameter int unsigned LEVELS     = plob_pkg::LEVELS_DEF,
  parameter int unsigned PRICE_BITS = plob_pkg::PRICE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    op_i,
  input  logic                          side_i,
  input  logic [plob_pkg::PORT_PX_W-1:0] price_i,
  input  logic [plob_pkg::SIZE_W-1:0]   size_i,
  input  logic [plob_pkg::PORT_PX_W-1:0] new_price_i,
  input  logic [plob_pkg::SIZE_W-1:0]   new_size_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [plob_pkg::SIZE_W-1:0]   filled_size_o,
  output logic [plob_pkg::SIZE_W-1:0]   rested_size_o,
  output logic [1:0]                    status_o,
  output logic [plob_pkg::PORT_PX_W-1:0] best_bid_o,
  output logic [plob_pkg::PORT_PX_W-1:0] best_ask_o,
  output logic                          bid_empty_o,
  output logic                          ask_empty_o
);
  import plob_pkg::*;

  logic      cmd_valid, cmd_ready;
  plob_cmd_t cmd;

  plob_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .side_i      (side_i),
    .price_i     (price_i),
    .size_i      (size_i),
    .new_price_i (new_price_i),
    .new_size_i  (new_size_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  plob_book #(
    .LEVELS     (LEVELS),
    .PRICE_BITS (PRICE_BITS)
  ) u_book (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .empty         (empty),
    .pop           (pop),
    .filled_size_o (filled_size_o),
    .rested_size_o (rested_size_o),
    .status_o      (status_o),
    .best_bid_o    (best_bid_o),
    .best_ask_o    (best_ask_o),
    .bid_empty_o   (bid_empty_o),
    .ask_empty_o   (ask_empty_o)
  );

endmodule

FILE: bench/tb_price_level_order_book_matcher.sv
// Testbench for the price-level order book matcher: a directed table with expected results,
// then random orders checked word by word against an in-bench model of the two level tables.
// Depends on plob_pkg and price_level_order_book_matcher.
`timescale 1ns / 100ps

module tb_price_level_order_book_matcher;
  import plob_pkg::*;

  localparam int unsigned NLVL = LEVELS_DEF;
  localparam int unsigned NUM_RANDOM = 1800;
  localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;
  localparam int BID = 1;
  localparam int ASK = 0;

  typedef struct {
    plob_op_e    op;
    bit          side;
    logic [31:0] price;
    logic [31:0] size;
    logic [31:0] new_price;
    logic [31:0] new_size;
  } order_word_t;

  typedef struct {
    logic [31:0]  filled;
    logic [31:0]  rested;
    plob_status_e status;
    logic [31:0]  best_bid;
    logic [31:0]  best_ask;
    bit           bid_empty;
    bit           ask_empty;
  } book_result_t;

  typedef struct {
    order_word_t  w;
    bit           typed;
    book_result_t r;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  op_i;
  logic        side_i;
  logic [31:0] price_i;
  logic [31:0] size_i;
  logic [31:0] new_price_i;
  logic [31:0] new_size_i;
  logic        empty;
  logic        pop;
  logic [31:0] filled_size_o;
  logic [31:0] rested_size_o;
  logic [1:0]  status_o;
  logic [31:0] best_bid_o;
  logic [31:0] best_ask_o;
  logic        bid_empty_o;
  logic        ask_empty_o;

  price_level_order_book_matcher uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .op_i(op_i), .side_i(side_i), .price_i(price_i), .size_i(size_i),
    .new_price_i(new_price_i), .new_size_i(new_size_i),
    .empty(empty), .pop(pop),
    .filled_size_o(filled_size_o), .rested_size_o(rested_size_o), .status_o(status_o),
    .best_bid_o(best_bid_o), .best_ask_o(best_ask_o),
    .bid_empty_o(bid_empty_o), .ask_empty_o(ask_empty_o)
  );

  // book model: index 1 bids (descending), index 0 asks (ascending)
  logic [31:0] lvl_px[2][NLVL];
  logic [31:0] lvl_sz[2][NLVL];
  int          lvl_cnt[2];

  book_result_t pending_results[$];
  int           errors;
  bit           quiet;
  dir_row_t     dir_rows[17];

  function automatic int find_level(int s, logic [31:0] p);
    for (int i = 0; i < lvl_cnt[s]; i++)
      if (lvl_px[s][i] == p) return i;
    return -1;
  endfunction

  function automatic void drop_level(int s, int idx);
    for (int i = idx; i < lvl_cnt[s] - 1; i++) begin
      lvl_px[s][i] = lvl_px[s][i+1];
      lvl_sz[s][i] = lvl_sz[s][i+1];
    end
    lvl_cnt[s]--;
  endfunction

  function automatic plob_status_e reduce_level(int s, logic [31:0] p, logic [31:0] amt);
    int f;
    f = find_level(s, p);
    if (f < 0) return ST_NOT_FOUND;
    if (amt >= lvl_sz[s][f]) drop_level(s, f);
    else lvl_sz[s][f] -= amt;
    return ST_OK;
  endfunction

  function automatic plob_status_e place_order(int s, logic [31:0] p, logic [31:0] qty,
                                               output logic [31:0] filled,
                                               output logic [31:0] rested);
    int o;
    int f;
    int pos;
    logic [31:0] need;
    o = 1 - s;
    need = qty;
    while (need != 0 && lvl_cnt[o] > 0 &&
           (s == BID ? lvl_px[o][0] <= p : lvl_px[o][0] >= p)) begin
      if (lvl_sz[o][0] <= need) begin
        need -= lvl_sz[o][0];
        drop_level(o, 0);
      end else begin
        lvl_sz[o][0] -= need;
        need = 0;
      end
    end
    filled = qty - need;
    rested = 0;
    if (need == 0) return ST_OK;
    f = find_level(s, p);
    if (f >= 0) begin
      lvl_sz[s][f] = (need > ALL1 - lvl_sz[s][f]) ? ALL1 : lvl_sz[s][f] + need;
      rested = need;
      return ST_OK;
    end
    if (lvl_cnt[s] >= NLVL) return ST_FULL;
    pos = lvl_cnt[s];
    for (int i = 0; i < lvl_cnt[s]; i++)
      if (s == BID ? lvl_px[s][i] < p : lvl_px[s][i] > p) begin
        pos = i;
        break;
      end
    for (int i = lvl_cnt[s]; i > pos; i--) begin
      lvl_px[s][i] = lvl_px[s][i-1];
      lvl_sz[s][i] = lvl_sz[s][i-1];
    end
    lvl_px[s][pos] = p;
    lvl_sz[s][pos] = need;
    lvl_cnt[s]++;
    rested = need;
    return ST_OK;
  endfunction

  function automatic book_result_t predict_book(order_word_t w);
    book_result_t r;
    plob_status_e s_old;
    int s;
    s = w.side ? BID : ASK;
    r.filled = 0;
    r.rested = 0;
    r.status = ST_OK;
    case (w.op)
      OP_NEW:    r.status = place_order(s, w.price, w.size, r.filled, r.rested);
      OP_REDUCE: r.status = reduce_level(s, w.price, w.size);
      OP_MODIFY: begin
        s_old = reduce_level(s, w.price, w.size);
        r.status = place_order(s, w.new_price, w.new_size, r.filled, r.rested);
        if (r.status == ST_OK) r.status = s_old;
      end
      default: ;
    endcase
    r.best_bid  = lvl_cnt[BID] > 0 ? lvl_px[BID][0] : 32'd0;
    r.best_ask  = lvl_cnt[ASK] > 0 ? lvl_px[ASK][0] : 32'd0;
    r.bid_empty = lvl_cnt[BID] == 0;
    r.ask_empty = lvl_cnt[ASK] == 0;
    return r;
  endfunction

  task automatic report_mismatch(string fld, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", fld, got, want, $realtime);
    errors++;
  endtask

  // drive one word from the falling edge until it is taken
  task automatic send_word(order_word_t w, bit typed, book_result_t r);
    book_result_t p;
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 9) begin
      push = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    push = 1'b1;
    op_i = w.op;
    side_i = w.side;
    price_i = w.price;
    size_i = w.size;
    new_price_i = w.new_price;
    new_size_i = w.new_size;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    p = predict_book(w);
    pending_results.push_back(typed ? r : p);
  endtask

  function automatic logic [31:0] pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 80) return $urandom_range(50, 1);
    if (k < 90) return $urandom;
    return k[0] ? ALL1 : 32'd0;
  endfunction

  function automatic logic [31:0] pick_price(int s, bit existing);
    int k;
    k = $urandom_range(99);
    if (existing && lvl_cnt[s] > 0 && k < 75)
      return lvl_px[s][$urandom_range(lvl_cnt[s] - 1)];
    if (k < 85) return $urandom_range(1020, 980);
    if (k < 93) return $urandom;
    return k[0] ? ALL1 : 32'd0;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400_000_000;
    $display("FAIL price_level_order_book_matcher");
    $finish;
  end

  // result side: pop with random stalls
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop = quiet || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    book_result_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (filled_size_o !== e.filled) report_mismatch("filled_size", filled_size_o, e.filled);
        if (rested_size_o !== e.rested) report_mismatch("rested_size", rested_size_o, e.rested);
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (best_bid_o !== e.best_bid) report_mismatch("best_bid", best_bid_o, e.best_bid);
        if (best_ask_o !== e.best_ask) report_mismatch("best_ask", best_ask_o, e.best_ask);
        if (bid_empty_o !== e.bid_empty) report_mismatch("bid_empty", bid_empty_o, e.bid_empty);
        if (ask_empty_o !== e.ask_empty) report_mismatch("ask_empty", ask_empty_o, e.ask_empty);
      end
    end
  end

  initial begin
    order_word_t  w;
    book_result_t none;
    int k;
    int n;
    errors = 0;
    quiet = 1'b0;
    lvl_cnt[0] = 0;
    lvl_cnt[1] = 0;
    none = '{0, 0, ST_OK, 0, 0, 1'b1, 1'b1};
    rst_ni = 1'b0;
    push = 1'b0;
    op_i = OP_NONE;
    side_i = 1'b0;
    price_i = '0;
    size_i = '0;
    new_price_i = '0;
    new_size_i = '0;

    dir_rows[0]  = '{'{OP_NONE, 1, 0, 0, 0, 0}, 1, none};
    dir_rows[1]  = '{'{OP_REDUCE, 1, 5, 1, 0, 0}, 1, '{0, 0, ST_NOT_FOUND, 0, 0, 1, 1}};
    dir_rows[2]  = '{'{OP_NEW, 1, 100, 0, 0, 0}, 1, none};
    dir_rows[3]  = '{'{OP_NEW, 1, 100, 10, 0, 0}, 1, '{0, 10, ST_OK, 100, 0, 0, 1}};
    dir_rows[4]  = '{'{OP_NEW, 1, ALL1, ALL1, 0, 0}, 1, '{0, ALL1, ST_OK, ALL1, 0, 0, 1}};
    // saturating add onto an existing level
    dir_rows[5]  = '{'{OP_NEW, 1, ALL1, 5, 0, 0}, 1, '{0, 5, ST_OK, ALL1, 0, 0, 1}};
    dir_rows[6]  = '{'{OP_NEW, 0, 0, 3, 0, 0}, 1, '{3, 0, ST_OK, ALL1, 0, 0, 1}};
    dir_rows[7]  = '{'{OP_REDUCE, 1, ALL1, ALL1, 0, 0}, 1, '{0, 0, ST_OK, 100, 0, 0, 1}};
    // sell at the bid price matches
    dir_rows[8]  = '{'{OP_NEW, 0, 100, 4, 0, 0}, 1, '{4, 0, ST_OK, 100, 0, 0, 1}};
    dir_rows[9]  = '{'{OP_NEW, 0, 200, 7, 0, 0}, 1, '{0, 7, ST_OK, 100, 200, 0, 0}};
    dir_rows[10] = '{'{OP_NEW, 1, 300, 20, 0, 0}, 1, '{7, 13, ST_OK, 300, 0, 0, 1}};
    dir_rows[11] = '{'{OP_MODIFY, 1, 300, 13, 50, 2}, 1, '{0, 2, ST_OK, 100, 0, 0, 1}};
    // modify of a missing level still places the new order
    dir_rows[12] = '{'{OP_MODIFY, 1, 999, 1, 60, 1}, 1, '{0, 1, ST_NOT_FOUND, 100, 0, 0, 1}};
    dir_rows[13] = '{'{OP_MODIFY, 0, 1, 1, 0, 0}, 1, '{0, 0, ST_NOT_FOUND, 100, 0, 0, 1}};
    dir_rows[14] = '{'{OP_REDUCE, 1, 100, 1, 0, 0}, 1, '{0, 0, ST_OK, 100, 0, 0, 1}};
    dir_rows[15] = '{'{OP_NEW, 0, 0, ALL1, 0, 0}, 1, '{8, 32'hFFFF_FFF7, ST_OK, 0, 0, 1, 0}};
    dir_rows[16] = '{'{OP_REDUCE, 0, 0, ALL1, 0, 0}, 1, none};

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

    for (n = 0; n < NUM_RANDOM; n++) begin
      quiet = (n >= 700 && n < 1000);
      // fill bursts drive one side past a full table
      if (n == 300 || n == 1300) begin
        for (int j = 0; j < NLVL + 6; j++) begin
          w = '{OP_NEW, (n == 300), 0, $urandom_range(20, 1), $urandom, $urandom};
          w.price = (n == 300) ? 32'd100 + j : 32'd5000 + j;
          send_word(w, 0, none);
        end
        w = '{OP_MODIFY, (n == 300), 0, 1, 0, 3};
        w.price = (n == 300) ? 32'd100 : 32'd5000;
        w.new_price = (n == 300) ? 32'd99 : 32'd4999;
        send_word(w, 0, none);
      end
      k = $urandom_range(99);
      w.side = $urandom_range(1);
      w.new_price = $urandom;
      w.new_size = $urandom;
      if (k < 55) begin
        w.op = OP_NEW;
        w.price = pick_price(w.side, 0);
        w.size = pick_size();
      end else if (k < 80) begin
        w.op = OP_REDUCE;
        w.price = pick_price(w.side, 1);
        w.size = pick_size();
      end else if (k < 96) begin
        w.op = OP_MODIFY;
        w.price = pick_price(w.side, 1);
        w.size = pick_size();
        w.new_price = pick_price(w.side, 0);
        w.new_size = pick_size();
      end else begin
        w.op = OP_NONE;
        w.price = $urandom;
        w.size = $urandom;
      end
      send_word(w, 0, none);
    end

    @(negedge clk_i);
    push = 1'b0;
    quiet = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS price_level_order_book_matcher");
    end else begin
      $display("FAIL price_level_order_book_matcher");
    end
    $finish;
  end

endmodule
